>>> hw/rtl/qidtt_pkg.sv
// Shared types, codes and constants for the query-ID translation table.
package qidtt_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int CFG_W           = 16;
  localparam int KEY_W           = 16;
  localparam int TMO_W           = 8;
  localparam int SEC_W           = 32;

  localparam logic [KEY_W-1:0] XOR_KEY_RST       = 16'h0000;
  localparam logic [TMO_W-1:0] STALE_TIMEOUT_RST = 8'd60;

  // Configuration register indexes.
  localparam logic REG_XOR_KEY       = 1'b0;
  localparam logic REG_STALE_TIMEOUT = 1'b1;

  // Operation codes on in_func.
  localparam logic [1:0] FUNC_SEND   = 2'd0;
  localparam logic [1:0] FUNC_ANSWER = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  // Result status codes.
  localparam logic [2:0] STAT_FORWARDED = 3'd0;
  localparam logic [2:0] STAT_REFUSED   = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_DELIVERED = 3'd3;
  localparam logic [2:0] STAT_UNTRACKED = 3'd4;
  localparam logic [2:0] STAT_DUPLICATE = 3'd5;
  localparam logic [2:0] STAT_TICK_DONE = 3'd6;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ANSWER
  } state_t;

  // Per-slot bookkeeping word.
  typedef struct packed {
    logic             used;
    logic             pending;
    logic [SEC_W-1:0] stamp;
  } meta_t;

  // Per-slot client word.
  typedef struct packed {
    logic [15:0] client_id;
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] socket;
  } data_t;

  localparam int META_W = $bits(meta_t);
  localparam int DATA_W = $bits(data_t);

endpackage

>>> hw/rtl/qidtt_mem.sv
// Simple dual-port synchronous memory, one write and one registered read port.
module qidtt_mem #(
  parameter int WIDTH = qidtt_pkg::META_W,
  parameter int DEPTH = qidtt_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/query_id_translation_table_top.sv
// Top level of the query-ID translation table: control, registers and slot memories.
// Refused, tick and out-of-range answer results appear in the cycle after the accept.
// An answer reads its slot, then reports; a send scans from slot 0 to a claim or full.
// Throughput: one item at a time; busy stays high while a send scan or an answer lookup
// runs. The scan reads one slot per cycle from the bookkeeping memory's single read port.
// Reset: synchronous, active low; afterwards a clearing pass writes every bookkeeping
// entry to unused, with busy high. Results cannot be stalled by the receiver.
module query_id_translation_table_top #(
  parameter int TABLE_DEPTH = qidtt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write port
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [qidtt_pkg::CFG_W-1:0] cfg_wdata,
  // command input
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_func,
  input  logic [15:0]                 in_query_id,
  input  logic [31:0]                 in_client_addr,
  input  logic [15:0]                 in_client_port,
  input  logic [15:0]                 in_client_socket,
  input  logic                        in_client_allowed,
  // results
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [15:0]                 out_wire_id,
  output logic [15:0]                 out_reply_id,
  output logic [31:0]                 out_reply_addr,
  output logic [15:0]                 out_reply_port,
  output logic [15:0]                 out_reply_socket,
  output logic                        out_stale_reused
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // Control state
  qidtt_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0]                  idx_r, idx_nxt;
  logic [qidtt_pkg::SEC_W-1:0]       sec_r, sec_nxt;
  logic [qidtt_pkg::KEY_W-1:0]       key_r;
  logic [qidtt_pkg::TMO_W-1:0]       tmo_r;

  // Latched send request (payload, no reset)
  logic [15:0] req_id_r;
  logic [31:0] req_addr_r;
  logic [15:0] req_port_r;
  logic [15:0] req_sock_r;

  // Result registers
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [15:0] out_wire_id_r, out_wire_id_nxt;
  logic [15:0] out_reply_id_r, out_reply_id_nxt;
  logic [31:0] out_reply_addr_r, out_reply_addr_nxt;
  logic [15:0] out_reply_port_r, out_reply_port_nxt;
  logic [15:0] out_reply_socket_r, out_reply_socket_nxt;
  logic        out_stale_r, out_stale_nxt;

  // Memory ports
  logic                           meta_we;
  logic [IDX_W-1:0]               meta_waddr;
  qidtt_pkg::meta_t               meta_wdata;
  logic [qidtt_pkg::META_W-1:0]   meta_rdata;
  qidtt_pkg::meta_t               meta_rd;
  logic                           data_we;
  qidtt_pkg::data_t               data_wdata;
  logic [qidtt_pkg::DATA_W-1:0]   data_rdata;
  qidtt_pkg::data_t               data_rd;
  logic                           rd_en;
  logic [IDX_W-1:0]               rd_addr;

  logic                           accept;
  logic [15:0]                    ans_slot;
  logic                           ans_in_range;
  logic [qidtt_pkg::SEC_W-1:0]    age;
  logic                           entry_free;
  logic                           entry_stale;

  qidtt_mem #(
    .WIDTH (qidtt_pkg::META_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_meta_mem (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (meta_rdata)
  );

  qidtt_mem #(
    .WIDTH (qidtt_pkg::DATA_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_data_mem (
    .clk   (clk),
    .we    (data_we),
    .waddr (idx_r),
    .wdata (data_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (data_rdata)
  );

  assign meta_rd = qidtt_pkg::meta_t'(meta_rdata);
  assign data_rd = qidtt_pkg::data_t'(data_rdata);

  assign busy   = (state_r != qidtt_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Answer ID maps back to a slot; anything at or past the depth is untracked.
  assign ans_slot     = in_query_id ^ key_r;
  assign ans_in_range = ({1'b0, ans_slot} < 17'(TABLE_DEPTH));

  // Slot under test in the scan: free, or pending past the timeout (ages wrap mod 2^32).
  assign age         = sec_r - meta_rd.stamp;
  assign entry_free  = !meta_rd.used || !meta_rd.pending;
  assign entry_stale = (age > {{(qidtt_pkg::SEC_W-qidtt_pkg::TMO_W){1'b0}}, tmo_r});

  assign data_wdata = '{client_id: req_id_r, addr: req_addr_r,
                        port: req_port_r, socket: req_sock_r};

  // Next state and result selection
  always_comb begin
    state_nxt            = state_r;
    idx_nxt              = idx_r;
    sec_nxt              = sec_r;
    out_valid_nxt        = 1'b0;
    out_status_nxt       = qidtt_pkg::STAT_FORWARDED;
    out_wire_id_nxt      = '0;
    out_reply_id_nxt     = '0;
    out_reply_addr_nxt   = '0;
    out_reply_port_nxt   = '0;
    out_reply_socket_nxt = '0;
    out_stale_nxt        = 1'b0;
    meta_we              = 1'b0;
    meta_waddr           = idx_r;
    meta_wdata           = '0;
    data_we              = 1'b0;
    rd_en                = 1'b0;
    rd_addr              = idx_r;

    unique case (state_r)
      qidtt_pkg::ST_CLEAR: begin
        // sweep the bookkeeping memory to unused, one slot a cycle
        meta_we = 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = qidtt_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      qidtt_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            qidtt_pkg::FUNC_SEND: begin
              if (!in_client_allowed) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = qidtt_pkg::STAT_REFUSED;
              end else begin
                // issue the read of slot 0; the scan checks it next cycle
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = qidtt_pkg::ST_SCAN;
              end
            end
            qidtt_pkg::FUNC_ANSWER: begin
              if (!ans_in_range) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = qidtt_pkg::STAT_UNTRACKED;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = ans_slot[IDX_W-1:0];
                idx_nxt   = ans_slot[IDX_W-1:0];
                state_nxt = qidtt_pkg::ST_ANSWER;
              end
            end
            qidtt_pkg::FUNC_TICK: begin
              sec_nxt        = sec_r + 1'b1;
              out_valid_nxt  = 1'b1;
              out_status_nxt = qidtt_pkg::STAT_TICK_DONE;
            end
            default: begin
              // unused selector: no result, no state change
            end
          endcase
        end
      end

      qidtt_pkg::ST_SCAN: begin
        priority if (entry_free || entry_stale) begin
          // claim the slot: stamp it pending and store the client
          meta_we         = 1'b1;
          meta_wdata      = '{used: 1'b1, pending: 1'b1, stamp: sec_r};
          data_we         = 1'b1;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = qidtt_pkg::STAT_FORWARDED;
          out_wire_id_nxt = 16'(idx_r) ^ key_r;
          out_stale_nxt   = !entry_free;
          state_nxt       = qidtt_pkg::ST_IDLE;
        end else if (idx_r == LAST_IDX) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = qidtt_pkg::STAT_FULL;
          state_nxt      = qidtt_pkg::ST_IDLE;
        end else begin
          // advance: fetch the next slot
          idx_nxt = idx_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_r + 1'b1;
        end
      end

      qidtt_pkg::ST_ANSWER: begin
        out_valid_nxt = 1'b1;
        state_nxt     = qidtt_pkg::ST_IDLE;
        priority if (!meta_rd.used) begin
          out_status_nxt = qidtt_pkg::STAT_UNTRACKED;
        end else if (!meta_rd.pending) begin
          out_status_nxt = qidtt_pkg::STAT_DUPLICATE;
        end else begin
          // drop the pending mark, keep the stamp; restore the client
          meta_we              = 1'b1;
          meta_wdata           = '{used: 1'b1, pending: 1'b0, stamp: meta_rd.stamp};
          out_status_nxt       = qidtt_pkg::STAT_DELIVERED;
          out_reply_id_nxt     = data_rd.client_id;
          out_reply_addr_nxt   = data_rd.addr;
          out_reply_port_nxt   = data_rd.port;
          out_reply_socket_nxt = data_rd.socket;
        end
      end

      default: begin
        state_nxt = qidtt_pkg::ST_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qidtt_pkg::ST_CLEAR;
      idx_r       <= '0;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= qidtt_pkg::XOR_KEY_RST;
      tmo_r <= qidtt_pkg::STALE_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qidtt_pkg::REG_XOR_KEY:       key_r <= cfg_wdata[qidtt_pkg::KEY_W-1:0];
        qidtt_pkg::REG_STALE_TIMEOUT: tmo_r <= cfg_wdata[qidtt_pkg::TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold the send request for the duration of the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      req_id_r   <= in_query_id;
      req_addr_r <= in_client_addr;
      req_port_r <= in_client_port;
      req_sock_r <= in_client_socket;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_status_r       <= out_status_nxt;
    out_wire_id_r      <= out_wire_id_nxt;
    out_reply_id_r     <= out_reply_id_nxt;
    out_reply_addr_r   <= out_reply_addr_nxt;
    out_reply_port_r   <= out_reply_port_nxt;
    out_reply_socket_r <= out_reply_socket_nxt;
    out_stale_r        <= out_stale_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_wire_id      = out_wire_id_r;
  assign out_reply_id     = out_reply_id_r;
  assign out_reply_addr   = out_reply_addr_r;
  assign out_reply_port   = out_reply_port_r;
  assign out_reply_socket = out_reply_socket_r;
  assign out_stale_reused = out_stale_r;

  // A tick always reports on the next cycle.
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == qidtt_pkg::FUNC_TICK) |=>
      (out_valid && out_status == qidtt_pkg::STAT_TICK_DONE))
    else $error("tick accepted without tick result");

  // A forwarded result comes only out of the scan.
  a_fwd_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == qidtt_pkg::STAT_FORWARDED) |->
      $past(state_r == qidtt_pkg::ST_SCAN))
    else $error("forwarded result outside scan");

  // A delivered result comes only out of the answer lookup.
  a_dlv_from_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == qidtt_pkg::STAT_DELIVERED) |->
      $past(state_r == qidtt_pkg::ST_ANSWER))
    else $error("delivered result outside answer lookup");

  // Write-back and read of the slot memories never fall in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !((meta_we || data_we) && rd_en))
    else $error("slot memory read and write in the same cycle");

endmodule
